/* rtl/hsd_pkg.sv */
// Shared constants and types of the Huffman stream decoder.
// No dependencies; the top level imports this package.
package hsd_pkg;

  localparam int unsigned MAX_SYMBOLS = 256;
  localparam int unsigned COUNT_BITS  = 32;

  localparam int unsigned ASM_W   = $clog2(COUNT_BITS);
  localparam int unsigned LEAF_W  = 9;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned REF_W   = 9;
  localparam int unsigned SP_W    = 9;
  localparam int unsigned DEPTH   = 256;

  typedef enum logic [5:0] {
    PH_COUNT   = 6'b000001,
    PH_LEAFCNT = 6'b000010,
    PH_LEAVES  = 6'b000100,
    PH_ROOT    = 6'b001000,
    PH_TREE    = 6'b010000,
    PH_DECODE  = 6'b100000
  } phase_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BIT   = 9'b000000010,
    S_POP   = 9'b000000100,
    S_LEAF  = 9'b000001000,
    S_LINK  = 9'b000010000,
    S_PUSHA = 9'b000100000,
    S_PUSHB = 9'b001000000,
    S_NODE  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } seq_e;

endpackage

/* rtl/hsd_if.sv */
// Handshake channels of the Huffman stream decoder: compressed bytes in,
// decoded symbols out. No dependencies.
interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  logic       stream_end;
  modport source (output valid, output symbol, output last, output stream_end, input ready);
  modport sink   (input valid, input symbol, input last, input stream_end, output ready);
endinterface

/* rtl/huffman_stream_decoder.sv */
// Huffman stream decoder top level: header parse, tree build and tree walk.
// Depends on hsd_pkg and the channel interfaces in hsd_if.sv.
//
//  channel | dir | word                              | accepted when
//  in_i    | in  | in_byte: compressed byte, LSB 1st | valid & ready
//  out_o   | out | symbol, last, stream_end          | valid & ready
//
// A byte is worked one bit per step under a small sequencer that
// shares each memory's write and read port (leaf table, left/right node
// tables, stack). Count, leaf-count and leaf bits are taken in S_BIT; a
// payload bit adds a node read in S_NODE; a shape bit pops the stack, then
// reads a leaf or clears a node, links it and may push two children. S_IDLE
// takes the byte and S_FLUSH closes it; when the payload ends inside a byte,
// drop the rest and close it early.
// Reset clears the sequencer and the header state; memories are not cleared.
// A stalled output holds the walk only when a second symbol is ready; the
// next byte is taken while the last symbol still waits in the output register.
module huffman_stream_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  hsd_in_if.sink    in_i,
  hsd_out_if.source out_o
);
  import hsd_pkg::*;

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;
  logic [7:0]            byte_q, byte_d;
  logic [2:0]            bidx_q, bidx_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [LEAF_W-1:0]     total_q, total_d;
  logic [LEAF_W-1:0]     cursor_q, cursor_d;
  logic [ASM_W-1:0]      asm_q, asm_d;
  logic [7:0]            leafb_q, leafb_d;
  logic [SP_W-1:0]       sp_q, sp_d;
  logic [ADDR_W-1:0]     alloc_q, alloc_d;
  logic [REF_W-1:0]      dnode_q, dnode_d;
  logic [ADDR_W-1:0]     node_q, node_d;
  logic                  side_q, side_d;
  logic [REF_W-1:0]      ref_q, ref_d;
  logic [ADDR_W-1:0]     pushn_q, pushn_d;
  logic                  ctx_root_q, ctx_root_d;
  logic                  pend_v_q, pend_v_d;
  logic [7:0]            pend_sym_q, pend_sym_d;
  logic                  pend_end_q, pend_end_d;
  logic                  out_v_q;
  logic [7:0]            out_sym_q;
  logic                  out_last_q, out_end_q;

  // memories
  logic [7:0]       leaf_mem [DEPTH];
  logic [REF_W-1:0] left_mem [DEPTH];
  logic [REF_W-1:0] right_mem [DEPTH];
  logic [REF_W-1:0] stack_mem [DEPTH];
  logic [7:0]       leaf_rd_q;
  logic [REF_W-1:0] left_rd_q, right_rd_q, stack_rd_q;

  logic              leaf_we, leaf_re;
  logic [ADDR_W-1:0] leaf_waddr, leaf_raddr;
  logic [7:0]        leaf_wdata;
  logic              left_we, right_we, node_re;
  logic [ADDR_W-1:0] node_waddr, node_raddr;
  logic [REF_W-1:0]  node_wdata;
  logic              stack_we, stack_re;
  logic [ADDR_W-1:0] stack_waddr, stack_raddr;
  logic [REF_W-1:0]  stack_wdata;

  logic              out_push, out_push_last, out_free;
  logic              cur_bit;

  assign cur_bit  = byte_q[bidx_q];
  assign out_free = !out_v_q || out_o.ready;
  assign in_i.ready = (seq_q == S_IDLE);

  always_comb begin
    logic [LEAF_W-1:0] tot;
    logic [7:0]        lb;
    logic [REF_W-1:0]  child;
    logic [COUNT_BITS-1:0] rem_dec;
    logic              advance, finish, leaf_fetch;

    seq_d = seq_q;          phase_d = phase_q;      byte_d = byte_q;
    bidx_d = bidx_q;        rem_d = rem_q;          total_d = total_q;
    cursor_d = cursor_q;    asm_d = asm_q;          leafb_d = leafb_q;
    sp_d = sp_q;            alloc_d = alloc_q;      dnode_d = dnode_q;
    node_d = node_q;        side_d = side_q;        ref_d = ref_q;
    pushn_d = pushn_q;      ctx_root_d = ctx_root_q;
    pend_v_d = pend_v_q;    pend_sym_d = pend_sym_q; pend_end_d = pend_end_q;
    leaf_we = 1'b0; leaf_re = 1'b0; leaf_waddr = cursor_q[ADDR_W-1:0];
    leaf_wdata = 8'd0; leaf_raddr = '0;
    left_we = 1'b0; right_we = 1'b0; node_re = 1'b0;
    node_waddr = '0; node_wdata = '0; node_raddr = dnode_q[ADDR_W-1:0];
    stack_we = 1'b0; stack_re = 1'b0; stack_waddr = sp_q[ADDR_W-1:0];
    stack_wdata = '0; stack_raddr = ADDR_W'(sp_q - SP_W'(1));
    out_push = 1'b0; out_push_last = 1'b0;
    tot = '0; lb = '0; child = '0; rem_dec = rem_q - COUNT_BITS'(1);
    advance = 1'b0; finish = 1'b0; leaf_fetch = 1'b0;

    unique case (seq_q)
      S_IDLE: begin
        if (in_i.valid) begin
          byte_d = in_i.in_byte;
          bidx_d = '0;
          seq_d  = S_BIT;
        end
      end
      S_BIT: begin
        unique case (phase_q)
          PH_LEAFCNT: begin
            tot = ((asm_q == '0) ? '0 : total_q) | (LEAF_W'(cur_bit) << asm_q[2:0]);
            if (asm_q == ASM_W'(7)) begin
              asm_d = '0;
              if (tot == '0) tot = LEAF_W'(256);
              if (tot > LEAF_W'(MAX_SYMBOLS)) tot = LEAF_W'(MAX_SYMBOLS);
              cursor_d = '0;
              phase_d  = PH_LEAVES;
            end else begin
              asm_d = asm_q + ASM_W'(1);
            end
            total_d = tot;
            advance = 1'b1;
          end
          PH_LEAVES: begin
            lb = ((asm_q == '0) ? 8'd0 : leafb_q) | (8'(cur_bit) << asm_q[2:0]);
            leafb_d = lb;
            if (asm_q == ASM_W'(7)) begin
              leaf_we    = 1'b1;
              leaf_wdata = lb;
              asm_d      = '0;
              if (cursor_q + LEAF_W'(1) >= total_q) begin
                cursor_d = '0;
                alloc_d  = '0;
                sp_d     = '0;
                dnode_d  = '0;
                phase_d  = PH_ROOT;
              end else begin
                cursor_d = cursor_q + LEAF_W'(1);
              end
            end else begin
              asm_d = asm_q + ASM_W'(1);
            end
            advance = 1'b1;
          end
          PH_ROOT: begin
            if (cur_bit) begin
              alloc_d  = ADDR_W'(1);
              dnode_d  = '0;
              left_we  = 1'b1;
              right_we = 1'b1;
              sp_d     = '0;
              pushn_d  = '0;
              phase_d  = PH_TREE;
              seq_d    = S_PUSHA;
            end else begin
              leaf_fetch = 1'b1;
              ctx_root_d = 1'b1;
            end
          end
          PH_TREE: begin
            if (sp_q == '0) begin
              finish = 1'b1;
            end else begin
              stack_re = 1'b1;
              sp_d     = sp_q - SP_W'(1);
              seq_d    = S_POP;
            end
          end
          PH_DECODE: begin
            rem_d = rem_dec;
            if (dnode_q[REF_W-1]) begin
              // one-leaf tree: consume the bit, give nothing
              if (rem_dec == '0) begin
                phase_d = PH_COUNT;
                seq_d   = S_FLUSH;
              end else begin
                advance = 1'b1;
              end
            end else begin
              node_re = 1'b1;
              seq_d   = S_NODE;
            end
          end
          default: begin
            rem_d = ((asm_q == '0) ? '0 : rem_q) | (COUNT_BITS'(cur_bit) << asm_q);
            if (asm_q == ASM_W'(COUNT_BITS - 1)) begin
              asm_d   = '0;
              phase_d = PH_LEAFCNT;
            end else begin
              asm_d = asm_q + ASM_W'(1);
            end
            advance = 1'b1;
          end
        endcase
      end
      S_POP: begin
        node_d = stack_rd_q[REF_W-1:1];
        side_d = stack_rd_q[0];
        if (cur_bit && alloc_q < ADDR_W'(MAX_SYMBOLS - 1)) begin
          left_we    = 1'b1;
          right_we   = 1'b1;
          node_waddr = alloc_q;
          ref_d      = {1'b0, alloc_q};
          alloc_d    = alloc_q + ADDR_W'(1);
          seq_d      = S_LINK;
        end else begin
          leaf_fetch = 1'b1;
          ctx_root_d = 1'b0;
        end
      end
      S_LEAF: begin
        if (ctx_root_q) begin
          dnode_d = {1'b1, leaf_rd_q};
          finish  = 1'b1;
        end else begin
          ref_d = {1'b1, leaf_rd_q};
          seq_d = S_LINK;
        end
      end
      S_LINK: begin
        node_waddr = node_q;
        node_wdata = ref_q;
        right_we   = side_q;
        left_we    = !side_q;
        if (!ref_q[REF_W-1] && sp_q <= SP_W'(DEPTH - 2)) begin
          pushn_d = ref_q[ADDR_W-1:0];
          seq_d   = S_PUSHA;
        end else if (sp_q == '0) begin
          finish = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      S_PUSHA: begin
        stack_we    = 1'b1;
        stack_wdata = {pushn_q, 1'b1};
        sp_d        = sp_q + SP_W'(1);
        seq_d       = S_PUSHB;
      end
      S_PUSHB: begin
        stack_we    = 1'b1;
        stack_wdata = {pushn_q, 1'b0};
        sp_d        = sp_q + SP_W'(1);
        advance     = 1'b1;
      end
      S_NODE: begin
        child = cur_bit ? right_rd_q : left_rd_q;
        if (child[REF_W-1] && pend_v_q && !out_free) begin
          // hold until the output register frees up
        end else begin
          if (child[REF_W-1]) begin
            out_push   = pend_v_q;
            pend_v_d   = 1'b1;
            pend_sym_d = child[7:0];
            pend_end_d = (rem_q == '0);
            dnode_d    = '0;
          end else begin
            dnode_d = child;
          end
          if (rem_q == '0) begin
            phase_d = PH_COUNT;
            seq_d   = S_FLUSH;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          seq_d = S_IDLE;
        end else if (out_free) begin
          out_push      = 1'b1;
          out_push_last = 1'b1;
          pend_v_d      = 1'b0;
          seq_d         = S_IDLE;
        end
      end
      default: seq_d = S_IDLE;
    endcase

    // next leaf of the shape: repeat the final leaf once all are used
    if (leaf_fetch) begin
      leaf_re = 1'b1;
      if (cursor_q < total_q) begin
        leaf_raddr = cursor_q[ADDR_W-1:0];
        cursor_d   = cursor_q + LEAF_W'(1);
      end else begin
        leaf_raddr = ADDR_W'(total_q - LEAF_W'(1));
      end
      seq_d = S_LEAF;
    end

    // tree complete: decode next, or drop the rest of the byte
    if (finish) begin
      if (rem_q == '0) begin
        phase_d = PH_COUNT;
        seq_d   = S_FLUSH;
      end else begin
        phase_d = PH_DECODE;
        advance = 1'b1;
      end
    end

    if (advance) begin
      if (bidx_q == 3'd7) begin
        seq_d = S_FLUSH;
      end else begin
        bidx_d = bidx_q + 3'd1;
        seq_d  = S_BIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= S_IDLE;
      phase_q    <= PH_COUNT;
      bidx_q     <= '0;
      rem_q      <= '0;
      total_q    <= '0;
      cursor_q   <= '0;
      asm_q      <= '0;
      sp_q       <= '0;
      alloc_q    <= '0;
      dnode_q    <= '0;
      ctx_root_q <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      phase_q    <= phase_d;
      bidx_q     <= bidx_d;
      rem_q      <= rem_d;
      total_q    <= total_d;
      cursor_q   <= cursor_d;
      asm_q      <= asm_d;
      sp_q       <= sp_d;
      alloc_q    <= alloc_d;
      dnode_q    <= dnode_d;
      ctx_root_q <= ctx_root_d;
      pend_v_q   <= pend_v_d;
      if (out_push) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    leafb_q    <= leafb_d;
    node_q     <= node_d;
    side_q     <= side_d;
    ref_q      <= ref_d;
    pushn_q    <= pushn_d;
    pend_sym_q <= pend_sym_d;
    pend_end_q <= pend_end_d;
    if (out_push) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= out_push_last;
      out_end_q  <= pend_end_q;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    if (leaf_re) leaf_rd_q <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (left_we)  left_mem[node_waddr]  <= node_wdata;
    if (right_we) right_mem[node_waddr] <= node_wdata;
    if (node_re) begin
      left_rd_q  <= left_mem[node_raddr];
      right_rd_q <= right_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rd_q <= stack_mem[stack_raddr];
  end

  assign out_o.valid      = out_v_q;
  assign out_o.symbol     = out_sym_q;
  assign out_o.last       = out_last_q;
  assign out_o.stream_end = out_end_q;

  // a new byte is only taken once the previous one has handed off its symbols
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_v_q) else $error("pending symbol while idle");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(DEPTH)) else $error("build stack overflow");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TREE || phase_q == PH_DECODE) |-> cursor_q <= total_q)
    else $error("leaf cursor past leaf count");

endmodule
